// ----- hw/rtl/obih_pkg.sv -----
// Package for the orientation-binned integral histogram.
// Field types, register indexes and fixed constants; no dependencies.
package obih_pkg;

   typedef logic [14:0] mag_type;
   typedef logic [14:0] ori_type;
   typedef logic [3:0]  bin_out_type;
   typedef logic [30:0] integ_type;
   typedef logic [1:0]  csr_idx_type;
   typedef logic [14:0] csr_data_type;
   typedef logic [10:0] width_reg_type;
   typedef logic [7:0]  pix_val_type;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_MAG_THRESHOLD = 2'd1
   } csr_addr_type;

   localparam integ_type     SAT_MAX         = 31'h7FFF_FFFF;
   localparam int unsigned   DEG_SCALE       = 23040;
   localparam width_reg_type WIDTH_RESET     = 11'd640;
   localparam mag_type       THRESHOLD_RESET = 15'd16;
   localparam pix_val_type   PIX_VAL_MAX     = 8'd255;

endpackage

// ----- hw/rtl/orientation_bin_integral_histogram.sv -----
// Top level of the orientation-binned integral histogram.
// Depends on obih_pkg; holds the pixel decode, bin sequencer and integral memory.
//
// Usage:
//  - req_ channel takes one pixel per beat: magnitude, orientation, frame_start.
//  - rsp_ channel returns BINS beats per pixel, bin 0 first; last_of_run marks
//    the beat for bin BINS-1. integral_value is the inclusive integral image
//    value of that bin at the pixel, saturating at 2^31-1.
//  - csr_ channel writes image_width (index 0) and mag_threshold (index 1); it is
//    always ready and must only be written while no pixel is in flight.
//  - Throughput: one result beat per cycle while the receiver does not stall, set by the
//    single read/write port pair of the integral memory (one bin per cycle).
//    The next pixel is taken during the last bin of the current one.
//  - Pipeline: pixel holding register (stage 1), stage 2 registers, output register.
//  - Reset: a clearing pass writes zero to all MAX_WIDTH*BINS memory entries,
//    one per cycle; req_ready stays low until the pass is done.
//  - When the receiver stalls, the output register holds the beat and the
//    pipeline stops behind it; no beat is dropped.
module orientation_bin_integral_histogram #(
   parameter int BINS      = 9,
   parameter int MAX_WIDTH = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  obih_pkg::mag_type    req_magnitude,
   input  obih_pkg::ori_type    req_orientation,
   input  logic                 req_frame_start,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output obih_pkg::bin_out_type rsp_bin_index,
   output obih_pkg::integ_type  rsp_integral_value,
   output logic                 rsp_last_of_run,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  obih_pkg::csr_idx_type csr_index,
   input  obih_pkg::csr_data_type csr_wdata
);
   import obih_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WCMP  = (CW + 1 > 11) ? CW + 1 : 11;
   localparam int DEPTH = MAX_WIDTH * BINS;
   localparam int AW    = $clog2(DEPTH);
   localparam int BW    = $clog2(BINS);
   localparam int NW    = 22;

   // configuration
   width_reg_type image_width_ff;
   mag_type       mag_threshold_ff;

   // frame position
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] base_ff, base_in;
   logic          first_ff, first_in;

   // clearing pass
   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;

   // pixel holding register
   logic          pix_valid_ff;
   logic [AW-1:0] pix_base_ff;
   logic          pix_first_ff, pix_fs_ff, pix_row_end_ff, pix_hit_en_ff;
   logic [BW-1:0] pix_hit_ff;
   pix_val_type   pix_val_ff;
   logic [BW-1:0] bcnt_ff;

   // row sums
   integ_type     rowsum_ff [BINS];

   // stage 2
   logic          s2_valid_ff, s2_first_ff, s2_last_ff;
   logic [AW-1:0] s2_addr_ff;
   logic [BW-1:0] s2_bin_ff;
   integ_type     s2_rs_ff;
   integ_type     rdata_ff;

   // output register
   logic          rsp_valid_ff, rsp_last_ff;
   bin_out_type   rsp_bin_ff;
   integ_type     rsp_integ_ff;

   integ_type     mem [DEPTH];

   logic              req_fire, s1_fire, s2_adv, beat_last;
   logic [WCMP-1:0]   w_ext, width_eff;
   logic [CW-1:0]     col_cur;
   logic [AW-1:0]     base_cur;
   logic              first_cur, row_end;
   logic [NW-1:0]     num2;
   logic [BW-1:0]     hit_bin;
   logic [10:0]       mq;
   logic [11:0]       mq_r;
   pix_val_type       mag_val;
   logic [AW-1:0]     s1_addr;
   integ_type         rs_old, rs_new;
   logic [31:0]       rs_sum, s2_sum;
   integ_type         above, s2_integ;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   integ_type         mem_wdata;
   logic [5:0]        bin_ext;

   assign csr_ready = 1'b1;
   assign beat_last = (bcnt_ff == BW'(BINS - 1));
   assign s2_adv    = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s1_fire   = pix_valid_ff && (!s2_valid_ff || s2_adv);
   assign req_ready = !clr_busy_ff && (!pix_valid_ff || (s1_fire && beat_last));
   assign req_fire  = req_valid && req_ready;

   // effective width, clamped to 1..MAX_WIDTH
   always_comb begin
      w_ext = WCMP'(image_width_ff);
      if (w_ext == '0) begin
         width_eff = WCMP'(1);
      end else if (w_ext > WCMP'(MAX_WIDTH)) begin
         width_eff = WCMP'(MAX_WIDTH);
      end else begin
         width_eff = w_ext;
      end
   end

   // column bookkeeping for the pixel being accepted
   always_comb begin
      col_cur   = req_frame_start ? '0 : col_ff;
      base_cur  = req_frame_start ? '0 : base_ff;
      first_cur = req_frame_start ? 1'b1 : first_ff;
      row_end   = (WCMP'(col_cur) + WCMP'(1)) >= width_eff;
      if (row_end) begin
         col_in   = '0;
         base_in  = '0;
         first_in = 1'b0;
      end else begin
         col_in   = col_cur + CW'(1);
         base_in  = base_cur + AW'(BINS);
         first_in = first_cur;
      end
   end

   // bin pick: count thresholds k passed by 2*o*(BINS-1) against (2k-1)*DEG_SCALE,
   // ties go to the even bin
   always_comb begin
      num2    = NW'(req_orientation) * NW'(2 * (BINS - 1));
      hit_bin = '0;
      for (int k = 1; k < BINS; k++) begin
         if ((num2 > NW'((2 * k - 1) * DEG_SCALE)) ||
             ((num2 == NW'((2 * k - 1) * DEG_SCALE)) && ((k % 2) == 0))) begin
            hit_bin = hit_bin + BW'(1);
         end
      end
   end

   // magnitude / 16, half to even, saturated
   always_comb begin
      mq = req_magnitude[14:4];
      if ((req_magnitude[3:0] > 4'd8) || ((req_magnitude[3:0] == 4'd8) && mq[0])) begin
         mq_r = {1'b0, mq} + 12'd1;
      end else begin
         mq_r = {1'b0, mq};
      end
      mag_val = (mq_r > 12'(PIX_VAL_MAX)) ? PIX_VAL_MAX : mq_r[7:0];
   end

   // stage 1 row sum update
   always_comb begin
      s1_addr = pix_base_ff + AW'(bcnt_ff);
      rs_old  = pix_fs_ff ? '0 : rowsum_ff[bcnt_ff];
      rs_sum  = {1'b0, rs_old} + 32'(pix_val_ff);
      if (pix_hit_en_ff && (pix_hit_ff == bcnt_ff)) begin
         rs_new = (rs_sum > {1'b0, SAT_MAX}) ? SAT_MAX : rs_sum[30:0];
      end else begin
         rs_new = rs_old;
      end
   end

   // stage 2 integral
   always_comb begin
      above    = s2_first_ff ? '0 : rdata_ff;
      s2_sum   = {1'b0, above} + {1'b0, s2_rs_ff};
      s2_integ = (s2_sum > {1'b0, SAT_MAX}) ? SAT_MAX : s2_sum[30:0];
   end

   always_comb begin
      if (clr_busy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = s2_adv;
         mem_waddr = s2_addr_ff;
         mem_wdata = s2_integ;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (s1_fire) begin
         rdata_ff <= mem[s1_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= WIDTH_RESET;
         mag_threshold_ff <= THRESHOLD_RESET;
         col_ff           <= '0;
         base_ff          <= '0;
         first_ff         <= 1'b1;
         clr_busy_ff      <= 1'b1;
         clr_addr_ff      <= '0;
         pix_valid_ff     <= 1'b0;
         bcnt_ff          <= '0;
         s2_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         for (int i = 0; i < BINS; i++) begin
            rowsum_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   image_width_ff   <= csr_wdata[10:0];
               CSR_MAG_THRESHOLD: mag_threshold_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (req_fire) begin
            col_ff   <= col_in;
            base_ff  <= base_in;
            first_ff <= first_in;
         end
         if (s1_fire) begin
            rowsum_ff[bcnt_ff] <= pix_row_end_ff ? '0 : rs_new;
            bcnt_ff            <= beat_last ? '0 : bcnt_ff + BW'(1);
         end
         if (req_fire) begin
            pix_valid_ff <= 1'b1;
         end else if (s1_fire && beat_last) begin
            pix_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_adv) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pix_base_ff    <= base_cur;
         pix_first_ff   <= first_cur;
         pix_fs_ff      <= req_frame_start;
         pix_row_end_ff <= row_end;
         pix_hit_en_ff  <= req_magnitude > mag_threshold_ff;
         pix_hit_ff     <= hit_bin;
         pix_val_ff     <= mag_val;
      end
      if (s1_fire) begin
         s2_addr_ff  <= s1_addr;
         s2_first_ff <= pix_first_ff;
         s2_bin_ff   <= bcnt_ff;
         s2_last_ff  <= beat_last;
         s2_rs_ff    <= rs_new;
      end
      if (s2_adv) begin
         rsp_bin_ff   <= bin_ext[3:0];
         rsp_integ_ff <= s2_integ;
         rsp_last_ff  <= s2_last_ff;
      end
   end

   assign bin_ext            = 6'(s2_bin_ff);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bin_index      = rsp_bin_ff;
   assign rsp_integral_value = rsp_integ_ff;
   assign rsp_last_of_run    = rsp_last_ff;

`ifndef SYNTH
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_ready)
      else $error("pixel accepted during memory clear");

   a_pixel_held: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !beat_last) |=> pix_valid_ff)
      else $error("pixel dropped before its last bin");

   a_last_reaches_out: assert property (@(posedge clock) disable iff (reset)
      (s2_adv && s2_last_ff) |=> (rsp_valid && rsp_last_of_run))
      else $error("last bin beat lost on the way out");

   a_bin_in_range: assert property (@(posedge clock) disable iff (reset)
      pix_valid_ff |-> (bcnt_ff <= BW'(BINS - 1)))
      else $error("bin counter out of range");
`endif

endmodule
